### design/cau_pkg.sv
package cau_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int WIDE_W     = 2 * DATA_WIDTH + 2;
	localparam int DEN_W      = 2 * DATA_WIDTH;
	localparam int REM_W      = DEN_W + 1;
	localparam int MAG_W      = WIDE_W + FRAC_BITS;
	localparam int QW         = DATA_WIDTH;
	localparam int CMP_W      = MAG_W + DEN_W;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_SCALE = 3'd4,
		OP_SOVC  = 3'd5,
		OP_DIVS  = 3'd6,
		OP_CONJ  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                          op;
		logic signed [DATA_WIDTH-1:0] a;
		logic signed [DATA_WIDTH-1:0] b;
		logic signed [DATA_WIDTH-1:0] c;
		logic signed [DATA_WIDTH-1:0] d;
		logic signed [DATA_WIDTH-1:0] x;
	} req_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [REM_W-1:0] rem;
		logic [QW-1:0]    low;
		logic [QW-1:0]    quo;
	} lane_t;

	typedef struct packed {
		logic                     is_div;
		logic                     dz;
		logic signed [WIDE_W-1:0] dir_re;
		logic signed [WIDE_W-1:0] dir_im;
		logic [DEN_W-1:0]         den;
		lane_t                    re;
		lane_t                    im;
	} mid_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result_re;
		logic signed [DATA_WIDTH-1:0] result_im;
		status_t                      status;
	} rsp_t;

endpackage

### design/cau_if.sv
interface cau_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [2:0]                            req_type;
	logic signed [cau_pkg::DATA_WIDTH-1:0] first_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0] first_im;
	logic signed [cau_pkg::DATA_WIDTH-1:0] second_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0] second_im;
	logic signed [cau_pkg::DATA_WIDTH-1:0] scalar_val;

	modport source(output valid, req_type, first_re, first_im, second_re, second_im,
		scalar_val, input ready);
	modport sink(input valid, req_type, first_re, first_im, second_re, second_im,
		scalar_val, output ready);
endinterface

interface cau_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cau_pkg::DATA_WIDTH-1:0] result_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0] result_im;
	logic [1:0]                            status;

	modport source(output valid, result_re, result_im, status, input ready);
	modport sink(input valid, result_re, result_im, status, output ready);
endinterface

### design/cau_front.sv
module cau_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cau_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cau_pkg::mid_t out_data
);

	typedef struct packed {
		cau_pkg::req_t                            req;
		logic [5:0][cau_pkg::PROD_W-1:0]          m;
	} prod_t;

	typedef struct packed {
		cau_pkg::op_t                             op;
		logic                                     is_div;
		logic                                     neg_den;
		logic signed [cau_pkg::WIDE_W-1:0]        num_re;
		logic signed [cau_pkg::WIDE_W-1:0]        num_im;
		logic [cau_pkg::DEN_W-1:0]                den;
		logic signed [cau_pkg::WIDE_W-1:0]        dir_re;
		logic signed [cau_pkg::WIDE_W-1:0]        dir_im;
	} comb_t;

	function automatic cau_pkg::lane_t prep_lane(logic signed [cau_pkg::WIDE_W-1:0] num,
		logic neg_den, logic [cau_pkg::DEN_W-1:0] den);
		cau_pkg::lane_t                l;
		logic [cau_pkg::WIDE_W-1:0]    av;
		logic [cau_pkg::MAG_W-1:0]     mag;
		logic [cau_pkg::MAG_W-1:0]     sh;
		av    = num[cau_pkg::WIDE_W-1] ? cau_pkg::WIDE_W'(-num) : cau_pkg::WIDE_W'(num);
		mag   = cau_pkg::MAG_W'(av) << cau_pkg::FRAC_BITS;
		sh    = mag >> cau_pkg::QW;
		l.neg = num[cau_pkg::WIDE_W-1] ^ neg_den;
		l.ovf = cau_pkg::CMP_W'(mag) >= (cau_pkg::CMP_W'(den) << cau_pkg::QW);
		l.rem = sh[cau_pkg::REM_W-1:0];
		l.low = mag[cau_pkg::QW-1:0];
		l.quo = '0;
		return l;
	endfunction

	cau_pkg::req_t req_s1;
	prod_t         prod_s2;
	comb_t         comb_s3;
	cau_pkg::mid_t mid_s4;
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          en1, en2, en3, en4;
	prod_t         prod_d;
	comb_t         comb_d;
	cau_pkg::mid_t mid_d;
	logic signed [cau_pkg::DATA_WIDTH-1:0] ma [6];
	logic signed [cau_pkg::DATA_WIDTH-1:0] mb [6];

	assign en4       = ~v_s4 | out_ready;
	assign en3       = ~v_s3 | en4;
	assign en2       = ~v_s2 | en3;
	assign en1       = ~v_s1 | en2;
	assign in_ready  = en1;
	assign out_valid = v_s4;
	assign out_data  = mid_s4;

	always_comb begin
		logic signed [cau_pkg::PROD_W-1:0] p;
		logic dual;
		dual  = (req_s1.op == cau_pkg::OP_MUL) || (req_s1.op == cau_pkg::OP_DIV);
		ma[0] = dual ? req_s1.a : req_s1.x;
		mb[0] = dual ? req_s1.c : req_s1.a;
		ma[1] = dual ? req_s1.b : req_s1.x;
		mb[1] = dual ? req_s1.d : req_s1.b;
		ma[2] = req_s1.a;
		mb[2] = req_s1.d;
		ma[3] = req_s1.b;
		mb[3] = req_s1.c;
		ma[4] = (req_s1.op == cau_pkg::OP_DIV) ? req_s1.c : req_s1.a;
		mb[4] = ma[4];
		ma[5] = (req_s1.op == cau_pkg::OP_DIV) ? req_s1.d : req_s1.b;
		mb[5] = ma[5];
		prod_d.req = req_s1;
		for (int k = 0; k < 6; k++) begin
			p = ma[k] * mb[k];
			prod_d.m[k] = p;
		end
	end

	always_comb begin
		logic signed [cau_pkg::WIDE_W-1:0] m0, m1, m2, m3;
		logic signed [cau_pkg::WIDE_W-1:0] a, b, c, d;
		logic signed [cau_pkg::DATA_WIDTH:0] xe;
		logic signed [cau_pkg::DATA_WIDTH:0] ax;
		logic [cau_pkg::DEN_W-1:0] sq;
		m0 = cau_pkg::WIDE_W'($signed(prod_s2.m[0]));
		m1 = cau_pkg::WIDE_W'($signed(prod_s2.m[1]));
		m2 = cau_pkg::WIDE_W'($signed(prod_s2.m[2]));
		m3 = cau_pkg::WIDE_W'($signed(prod_s2.m[3]));
		a  = cau_pkg::WIDE_W'(prod_s2.req.a);
		b  = cau_pkg::WIDE_W'(prod_s2.req.b);
		c  = cau_pkg::WIDE_W'(prod_s2.req.c);
		d  = cau_pkg::WIDE_W'(prod_s2.req.d);
		xe = (cau_pkg::DATA_WIDTH+1)'(prod_s2.req.x);
		ax = xe[cau_pkg::DATA_WIDTH] ? -xe : xe;
		sq = prod_s2.m[4] + prod_s2.m[5];
		comb_d.op      = prod_s2.req.op;
		comb_d.is_div  = 1'b0;
		comb_d.neg_den = 1'b0;
		comb_d.num_re  = '0;
		comb_d.num_im  = '0;
		comb_d.den     = sq;
		comb_d.dir_re  = '0;
		comb_d.dir_im  = '0;
		unique case (prod_s2.req.op)
			cau_pkg::OP_ADD: begin
				comb_d.dir_re = a + c;
				comb_d.dir_im = b + d;
			end
			cau_pkg::OP_SUB: begin
				comb_d.dir_re = a - c;
				comb_d.dir_im = b - d;
			end
			cau_pkg::OP_MUL: begin
				comb_d.dir_re = (m0 - m1) >>> cau_pkg::FRAC_BITS;
				comb_d.dir_im = (m2 + m3) >>> cau_pkg::FRAC_BITS;
			end
			cau_pkg::OP_DIV: begin
				comb_d.is_div = 1'b1;
				comb_d.num_re = m0 + m1;
				comb_d.num_im = m3 - m2;
			end
			cau_pkg::OP_SCALE: begin
				comb_d.dir_re = m0 >>> cau_pkg::FRAC_BITS;
				comb_d.dir_im = m1 >>> cau_pkg::FRAC_BITS;
			end
			cau_pkg::OP_SOVC: begin
				comb_d.is_div = 1'b1;
				comb_d.num_re = m0;
				comb_d.num_im = -m1;
			end
			cau_pkg::OP_DIVS: begin
				comb_d.is_div  = 1'b1;
				comb_d.num_re  = a;
				comb_d.num_im  = b;
				comb_d.neg_den = prod_s2.req.x[cau_pkg::DATA_WIDTH-1];
				comb_d.den     = cau_pkg::DEN_W'($unsigned(ax));
			end
			cau_pkg::OP_CONJ: begin
				comb_d.dir_re = a;
				comb_d.dir_im = -b;
			end
		endcase
	end

	always_comb begin
		mid_d.is_div = comb_s3.is_div;
		mid_d.dz     = comb_s3.den == '0;
		mid_d.dir_re = comb_s3.dir_re;
		mid_d.dir_im = comb_s3.dir_im;
		mid_d.den    = comb_s3.den;
		mid_d.re     = prep_lane(comb_s3.num_re, comb_s3.neg_den, comb_s3.den);
		mid_d.im     = prep_lane(comb_s3.num_im, comb_s3.neg_den, comb_s3.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) req_s1 <= in_data;
		if (en2) prod_s2 <= prod_d;
		if (en3) comb_s3 <= comb_d;
		if (en4) mid_s4 <= mid_d;
	end

endmodule

### design/cau_div.sv
module cau_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cau_pkg::mid_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cau_pkg::mid_t out_data
);

	function automatic cau_pkg::lane_t div_step(cau_pkg::lane_t l,
		logic [cau_pkg::DEN_W-1:0] den);
		cau_pkg::lane_t           o;
		logic [cau_pkg::REM_W-1:0] r;
		o = l;
		r = {l.rem[cau_pkg::REM_W-2:0], l.low[cau_pkg::QW-1]};
		o.low = l.low << 1;
		if (r >= cau_pkg::REM_W'(den)) begin
			r     = r - cau_pkg::REM_W'(den);
			o.quo = {l.quo[cau_pkg::QW-2:0], 1'b1};
		end else begin
			o.quo = {l.quo[cau_pkg::QW-2:0], 1'b0};
		end
		o.rem = r;
		return o;
	endfunction

	cau_pkg::mid_t           pipe_s [cau_pkg::QW];
	logic [cau_pkg::QW-1:0]  vld_s;
	logic [cau_pkg::QW-1:0]  en;

	always_comb begin
		en[cau_pkg::QW-1] = ~vld_s[cau_pkg::QW-1] | out_ready;
		for (int k = cau_pkg::QW - 2; k >= 0; k--) begin
			en[k] = ~vld_s[k] | en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[cau_pkg::QW-1];
	assign out_data  = pipe_s[cau_pkg::QW-1];

	for (genvar k = 0; k < cau_pkg::QW; k++) begin : g_stage
		cau_pkg::mid_t src;
		cau_pkg::mid_t nxt;
		logic          src_v;

		if (k == 0) begin : g_first
			assign src   = in_data;
			assign src_v = in_valid;
		end else begin : g_rest
			assign src   = pipe_s[k-1];
			assign src_v = vld_s[k-1];
		end

		always_comb begin
			nxt    = src;
			nxt.re = div_step(src.re, src.den);
			nxt.im = div_step(src.im, src.den);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) pipe_s[k] <= nxt;
		end
	end

endmodule

### design/cau_back.sv
module cau_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cau_pkg::mid_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cau_pkg::rsp_t out_data
);

	localparam logic [cau_pkg::DATA_WIDTH-1:0] MaxV = {1'b0, {(cau_pkg::DATA_WIDTH-1){1'b1}}};
	localparam logic [cau_pkg::DATA_WIDTH-1:0] MinV = {1'b1, {(cau_pkg::DATA_WIDTH-1){1'b0}}};

	function automatic logic [cau_pkg::DATA_WIDTH:0] sat_dir(
		logic signed [cau_pkg::WIDE_W-1:0] v);
		logic [cau_pkg::WIDE_W-cau_pkg::DATA_WIDTH:0] top;
		top = v[cau_pkg::WIDE_W-1:cau_pkg::DATA_WIDTH-1];
		if ((&top) || !(|top)) return {1'b0, v[cau_pkg::DATA_WIDTH-1:0]};
		return {1'b1, v[cau_pkg::WIDE_W-1] ? MinV : MaxV};
	endfunction

	function automatic logic [cau_pkg::DATA_WIDTH:0] sat_div(cau_pkg::lane_t l);
		if (!l.neg) begin
			if (l.ovf || l.quo[cau_pkg::QW-1]) return {1'b1, MaxV};
			return {1'b0, l.quo};
		end
		if (l.ovf || (l.quo > MinV)) return {1'b1, MinV};
		return {1'b0, cau_pkg::DATA_WIDTH'(-l.quo)};
	endfunction

	cau_pkg::rsp_t out_q;
	cau_pkg::rsp_t rsp_d;
	logic          vld_q;
	logic          en;

	assign en        = ~vld_q | out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q;
	assign out_data  = out_q;

	always_comb begin
		logic [cau_pkg::DATA_WIDTH:0] re;
		logic [cau_pkg::DATA_WIDTH:0] im;
		if (in_data.is_div) begin
			re = sat_div(in_data.re);
			im = sat_div(in_data.im);
		end else begin
			re = sat_dir(in_data.dir_re);
			im = sat_dir(in_data.dir_im);
		end
		if (in_data.is_div && in_data.dz) begin
			rsp_d.result_re = '0;
			rsp_d.result_im = '0;
			rsp_d.status    = cau_pkg::ST_DZ;
		end else begin
			rsp_d.result_re = re[cau_pkg::DATA_WIDTH-1:0];
			rsp_d.result_im = im[cau_pkg::DATA_WIDTH-1:0];
			rsp_d.status    = (re[cau_pkg::DATA_WIDTH] || im[cau_pkg::DATA_WIDTH]) ?
				cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= rsp_d;
	end

endmodule

### design/complex_arithmetic_unit.sv
// Signed Q16.16 complex ALU. An accepted request passes through operand capture, the
// six 32 by 32 multipliers, summing and divisor preparation, then a pipelined
// restoring divider that yields one quotient bit per stage, and saturation into the
// output register. Every opcode passes through the same stages, so a new request is
// taken every cycle while the result side is not stalled, and results leave in request
// order; back-pressure on the result side stalls only the stages that are full, and a
// stall loses or repeats no transaction.
module complex_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);

	cau_pkg::req_t in_data;
	cau_pkg::mid_t front_data;
	cau_pkg::mid_t div_data;
	cau_pkg::rsp_t out_data;
	logic          front_valid, front_ready;
	logic          div_valid, div_ready;

	assign in_data.op = cau_pkg::op_t'(req.req_type);
	assign in_data.a  = req.first_re;
	assign in_data.b  = req.first_im;
	assign in_data.c  = req.second_re;
	assign in_data.d  = req.second_im;
	assign in_data.x  = req.scalar_val;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_data   (in_data),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	cau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_data   (div_data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

	assign rsp.result_re = out_data.result_re;
	assign rsp.result_im = out_data.result_im;
	assign rsp.status    = out_data.status;

endmodule

### design/cau_checker.sv
module cau_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  req_valid,
	input logic                                  req_ready,
	input logic                                  rsp_valid,
	input logic                                  rsp_ready,
	input logic signed [cau_pkg::DATA_WIDTH-1:0] result_re,
	input logic signed [cau_pkg::DATA_WIDTH-1:0] result_im,
	input logic [1:0]                            status
);

	localparam logic [cau_pkg::DATA_WIDTH-1:0] MaxV = {1'b0, {(cau_pkg::DATA_WIDTH-1){1'b1}}};
	localparam logic [cau_pkg::DATA_WIDTH-1:0] MinV = {1'b1, {(cau_pkg::DATA_WIDTH-1){1'b0}}};

	// A result transaction that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// Requests are refused only when the whole pipeline is full and the output is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without a stalled result");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == cau_pkg::ST_DZ |-> result_re == '0 && result_im == '0)
		else $error("divide-by-zero result is not zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == cau_pkg::ST_SAT |->
			result_re == MaxV || result_re == MinV || result_im == MaxV || result_im == MinV)
		else $error("saturated result not at a bound");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.result_re (rsp.result_re),
	.result_im (rsp.result_im),
	.status    (rsp.status)
);

### sim/cau_checker.sv
`timescale 1ns / 1ps

module cau_scoreboard
	import cau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cau_req_if   req,
	cau_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef logic signed [255:0] wide_t;

	rsp_t awaited_results[$];

	function automatic logic signed [DATA_WIDTH-1:0] clamp_component(input wide_t v,
		inout bit sat);
		if (v > 256'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end else if (v < -256'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	function automatic rsp_t compute_complex(input op_t op,
		input logic signed [DATA_WIDTH-1:0] a, b, c, d, x);
		wide_t wa, wb, wc, wd, wx, re, im, den;
		bit    sat;
		bit    dz;
		rsp_t  r;
		wa = a;
		wb = b;
		wc = c;
		wd = d;
		wx = x;
		re = 0;
		im = 0;
		sat = 1'b0;
		dz = 1'b0;
		case (op)
			OP_ADD: begin
				re = wa + wc;
				im = wb + wd;
			end
			OP_SUB: begin
				re = wa - wc;
				im = wb - wd;
			end
			OP_MUL: begin
				re = (wa * wc - wb * wd) >>> FRAC_BITS;
				im = (wa * wd + wb * wc) >>> FRAC_BITS;
			end
			OP_DIV: begin
				den = wc * wc + wd * wd;
				if (den == 0) begin
					dz = 1'b1;
				end else begin
					re = ((wa * wc + wb * wd) <<< FRAC_BITS) / den;
					im = ((wb * wc - wa * wd) <<< FRAC_BITS) / den;
				end
			end
			OP_SCALE: begin
				re = (wx * wa) >>> FRAC_BITS;
				im = (wx * wb) >>> FRAC_BITS;
			end
			OP_SOVC: begin
				den = wa * wa + wb * wb;
				if (den == 0) begin
					dz = 1'b1;
				end else begin
					re = ((wx * wa) <<< FRAC_BITS) / den;
					im = ((-(wx * wb)) <<< FRAC_BITS) / den;
				end
			end
			OP_DIVS: begin
				if (wx == 0) begin
					dz = 1'b1;
				end else begin
					re = (wa <<< FRAC_BITS) / wx;
					im = (wb <<< FRAC_BITS) / wx;
				end
			end
			default: begin
				re = wa;
				im = -wb;
			end
		endcase
		if (dz) begin
			r.result_re = '0;
			r.result_im = '0;
			r.status = ST_DZ;
		end else begin
			r.result_re = clamp_component(re, sat);
			r.result_im = clamp_component(im, sat);
			r.status = sat ? ST_SAT : ST_OK;
		end
		return r;
	endfunction

	assign pending = awaited_results.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && req.valid && req.ready) begin
			awaited_results.push_back(compute_complex(op_t'(req.req_type), req.first_re,
				req.first_im, req.second_re, req.second_im, req.scalar_val));
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected transaction re=%h im=%h status=%0d", $time,
					rsp.result_re, rsp.result_im, rsp.status);
				fail_count = fail_count + 1;
			end else begin
				want = awaited_results.pop_front();
				if (rsp.result_re !== want.result_re) begin
					$display("%0t: result_re expected %h actual %h", $time,
						want.result_re, rsp.result_re);
					fail_count = fail_count + 1;
				end
				if (rsp.result_im !== want.result_im) begin
					$display("%0t: result_im expected %h actual %h", $time,
						want.result_im, rsp.result_im);
					fail_count = fail_count + 1;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp.status);
					fail_count = fail_count + 1;
				end
			end
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cau_pkg::*;

	localparam int NUM_RANDOM = 830;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	int   cycle;
	int   fail_count;
	int   pending;
	bit   sender_steady;

	cau_req_if req ();
	cau_rsp_if rsp ();

	complex_arithmetic_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	cau_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("[complex_arithmetic_unit] ERROR");
			$finish;
		end
	end

	// The receiver stalls for a long stretch early on so that the pipeline fills.
	always @(posedge clk) begin
		if (cycle >= 600 && cycle < 900) begin
			rsp.ready <= 1'b0;
		end else if (cycle >= 1500 && cycle < 2500) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= 38);
		end
	end

	function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return $signed(32'($urandom_range(32'h3ffff)));
			4: return -$signed(32'($urandom_range(32'h3ffff)));
			5: return $signed(32'($urandom_range(32'h7ffffff))) - 32'sh4000000;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic send_request(input op_t op, input logic signed [DATA_WIDTH-1:0] a, b,
		c, d, x);
		while (!sender_steady && $urandom_range(99) < 38) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= op;
		req.first_re <= a;
		req.first_im <= b;
		req.second_re <= c;
		req.second_im <= d;
		req.scalar_val <= x;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	initial begin
		cycle = 0;
		sender_steady = 1'b0;
		arst_n = 1'b0;
		rsp.ready = 1'b0;
		req.valid = 1'b0;
		req.req_type = OP_ADD;
		req.first_re = '0;
		req.first_im = '0;
		req.second_re = '0;
		req.second_im = '0;
		req.scalar_val = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_ADD, 32'sh00010000, 32'sh00020000, 32'sh00030000, -32'sh10000, 0);
		send_request(OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 5);
		send_request(OP_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, -32'sh1, 0);
		send_request(OP_SUB, 32'sh12345678, -32'sh5555, 32'sh00001111, 32'sh7fffffff, 0);
		send_request(OP_MUL, 32'sh00020000, 32'sh00030000, 32'sh00040000, -32'sh50000, 0);
		send_request(OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0);
		send_request(OP_MUL, -32'sh1, 32'sh1, 32'sh1, 32'sh1, 0);
		send_request(OP_DIV, 32'sh00010000, 32'sh00010000, 32'sh00020000, 32'sh00000000, 0);
		send_request(OP_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh00000001, 32'sh00000000, 0);
		send_request(OP_DIV, 32'sh00050000, 32'sh00010000, 32'sh00000000, 32'sh00000000, 7);
		send_request(OP_DIV, -32'sh30000, 32'sh70000, 32'sh80000000, 32'sh80000000, 0);
		send_request(OP_SCALE, 32'sh00018000, -32'sh28000, 0, 0, 32'sh00030000);
		send_request(OP_SCALE, 32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh80000000);
		send_request(OP_SOVC, 32'sh00010000, 32'sh00010000, 0, 0, 32'sh00020000);
		send_request(OP_SOVC, 32'sh00000000, 32'sh00000000, 3, 4, 32'sh00020000);
		send_request(OP_SOVC, 32'sh00000001, 32'sh00000000, 0, 0, 32'sh7fffffff);
		send_request(OP_DIVS, 32'sh00030000, -32'sh60000, 0, 0, 32'sh00020000);
		send_request(OP_DIVS, 32'sh7fffffff, 32'sh80000000, 0, 0, 32'sh00000001);
		send_request(OP_DIVS, 32'sh00030000, 32'sh00040000, 9, 9, 32'sh00000000);
		send_request(OP_DIVS, -32'sh7, 32'sh7, 0, 0, -32'sh30000);
		send_request(OP_CONJ, 32'sh12345678, 32'sh80000000, 1, 2, 3);
		send_request(OP_CONJ, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			sender_steady = (i >= 400 && i < 600);
			send_request(op_t'($urandom_range(7)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand(), pick_operand());
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[complex_arithmetic_unit] OK");
		end else begin
			$display("[complex_arithmetic_unit] ERROR");
		end
		$finish;
	end

endmodule
